FILE: rtl/lpht_pkg.sv
// Shared types, constants and helpers for the linear probing hash table.
package lpht_pkg;

	localparam int CAPACITY = 256;
	localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int EFF_W    = IDX_W + 1;
	localparam int SIZE_W   = 9;
	localparam int KEY_W    = 32;
	localparam int VAL_W    = 32;

	localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(256);

	typedef enum logic {
		REQ_GET = 1'b0,
		REQ_SET = 1'b1
	} req_type_t;

	typedef struct packed {
		logic             req_type;
		logic [KEY_W-1:0] key;
		logic [VAL_W-1:0] write_value;
	} req_t;

	typedef struct packed {
		logic [VAL_W-1:0] read_value;
		logic             hit;
		logic             table_full;
	} rsp_t;

	typedef struct packed {
		logic             rd_en;
		logic [IDX_W-1:0] rd_addr;
		logic             we;
		logic [IDX_W-1:0] wr_addr;
		logic [KEY_W-1:0] wr_key;
		logic [VAL_W-1:0] wr_value;
	} store_ctl_t;

	function automatic logic [EFF_W-1:0] eff_size(input logic [SIZE_W-1:0] ts);
		logic [EFF_W-1:0] s;
		if (ts == '0) begin
			s = EFF_W'(1);
		end else if (32'(ts) > CAPACITY) begin
			s = EFF_W'(CAPACITY);
		end else begin
			s = EFF_W'(ts);
		end
		return s;
	endfunction

endpackage

FILE: rtl/lpht_mod.sv
// Bit-serial remainder unit: key modulo table size, one dividend bit per cycle.
module lpht_mod (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [lpht_pkg::KEY_W-1:0]        dividend,
	input  logic [lpht_pkg::EFF_W-1:0]        divisor,
	output logic                              done,
	output logic [lpht_pkg::IDX_W-1:0]        rem
);

	localparam int CNT_W = $clog2(lpht_pkg::KEY_W);

	logic                           run_q;
	logic                           done_q;
	logic [CNT_W-1:0]               cnt_q;
	logic [lpht_pkg::KEY_W-1:0]     dvd_q;
	logic [lpht_pkg::EFF_W-1:0]     div_q;
	logic [lpht_pkg::EFF_W-1:0]     rem_q;
	logic [lpht_pkg::EFF_W:0]       trial;
	logic [lpht_pkg::EFF_W:0]       trial_sub;

	always_comb begin
		trial     = {rem_q, dvd_q[lpht_pkg::KEY_W-1]};
		trial_sub = (trial >= {1'b0, div_q}) ? (trial - {1'b0, div_q}) : trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(lpht_pkg::KEY_W - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			div_q <= divisor;
			rem_q <= '0;
		end else if (run_q) begin
			dvd_q <= {dvd_q[lpht_pkg::KEY_W-2:0], 1'b0};
			rem_q <= trial_sub[lpht_pkg::EFF_W-1:0];
		end
	end

	assign done = done_q;
	assign rem  = rem_q[lpht_pkg::IDX_W-1:0];

endmodule

FILE: rtl/lpht_store.sv
// Key and value memories with per-slot valid bits; one read and one write port.
module lpht_store (
	input  logic                          clk,
	input  logic                          arst_n,
	input  lpht_pkg::store_ctl_t          ctl,
	output logic [lpht_pkg::KEY_W-1:0]    rd_key,
	output logic [lpht_pkg::VAL_W-1:0]    rd_value
);

	logic [lpht_pkg::KEY_W-1:0]  key_mem   [lpht_pkg::CAPACITY];
	logic [lpht_pkg::VAL_W-1:0]  value_mem [lpht_pkg::CAPACITY];
	logic [lpht_pkg::CAPACITY-1:0] valid_q;
	logic                        rd_valid_q;
	logic [lpht_pkg::KEY_W-1:0]  rd_key_q;
	logic [lpht_pkg::VAL_W-1:0]  rd_value_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (ctl.we) begin
				valid_q[ctl.wr_addr] <= 1'b1;
			end
			if (ctl.rd_en) begin
				rd_valid_q <= valid_q[ctl.rd_addr];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.we) begin
			key_mem[ctl.wr_addr]   <= ctl.wr_key;
			value_mem[ctl.wr_addr] <= ctl.wr_value;
		end
		if (ctl.rd_en) begin
			rd_key_q   <= key_mem[ctl.rd_addr];
			rd_value_q <= value_mem[ctl.rd_addr];
		end
	end

	assign rd_key   = rd_valid_q ? rd_key_q : '0;
	assign rd_value = rd_valid_q ? rd_value_q : '0;

endmodule

FILE: rtl/linear_probe_hash_table_top.sv
// Linear probing hash table: request sequencer around the remainder unit and stores.
// A request with key zero returns its result in the cycle after acceptance.
// Otherwise the remainder unit computes the home slot, then each probed slot passes
// through a memory read and a compare state; the result strobe follows the last compare.
// One transaction at a time; busy stays high until the result strobe.
// Reset empties every slot and sets table_size to 256; results cannot be stalled.
module linear_probe_hash_table_top (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  lpht_pkg::req_t                  req,
	output logic                            busy,
	output logic                            done,
	output lpht_pkg::rsp_t                  rsp,
	input  logic                            cfg_we,
	input  logic [lpht_pkg::SIZE_W-1:0]     cfg_wdata
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_HASH,
		S_RD,
		S_CHK
	} state_t;

	state_t                          state_q;
	logic [lpht_pkg::SIZE_W-1:0]     table_size_q;
	lpht_pkg::req_t                  req_q;
	logic [lpht_pkg::EFF_W-1:0]      eff_q;
	logic [lpht_pkg::EFF_W-1:0]      cnt_q;
	logic [lpht_pkg::IDX_W-1:0]      idx_q;
	logic                            done_q;
	lpht_pkg::rsp_t                  rsp_q;

	logic                            accept;
	logic                            mod_start;
	logic                            mod_done;
	logic [lpht_pkg::IDX_W-1:0]      mod_rem;
	lpht_pkg::store_ctl_t            st_ctl;
	logic [lpht_pkg::KEY_W-1:0]      rd_key;
	logic [lpht_pkg::VAL_W-1:0]      rd_value;
	logic                            key_match;
	logic                            slot_empty;
	logic [lpht_pkg::EFF_W-1:0]      idx_inc;
	logic                            is_set;

	assign accept     = start && (state_q == S_IDLE);
	assign mod_start  = accept && (req.key != '0);
	assign key_match  = (rd_key == req_q.key);
	assign slot_empty = (rd_key == '0);
	assign idx_inc    = {1'b0, idx_q} + lpht_pkg::EFF_W'(1);
	assign is_set     = (req_q.req_type == lpht_pkg::REQ_SET);

	always_comb begin
		st_ctl          = '0;
		st_ctl.rd_en    = (state_q == S_RD);
		st_ctl.rd_addr  = idx_q;
		st_ctl.we       = (state_q == S_CHK) && is_set && (key_match || slot_empty);
		st_ctl.wr_addr  = idx_q;
		st_ctl.wr_key   = req_q.key;
		st_ctl.wr_value = req_q.write_value;
	end

	lpht_mod u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (mod_start),
		.dividend (req.key),
		.divisor  (lpht_pkg::eff_size(table_size_q)),
		.done     (mod_done),
		.rem      (mod_rem)
	);

	lpht_store u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (st_ctl),
		.rd_key   (rd_key),
		.rd_value (rd_value)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			table_size_q <= lpht_pkg::SIZE_RESET;
		end else if (cfg_we) begin
			table_size_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
			rsp_q   <= '0;
			idx_q   <= '0;
			cnt_q   <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						cnt_q <= '0;
						if (req.key == '0) begin
							done_q <= 1'b1;
							rsp_q  <= '0;
						end else begin
							state_q <= S_HASH;
						end
					end
				end
				S_HASH: begin
					if (mod_done) begin
						idx_q   <= mod_rem;
						state_q <= S_RD;
					end
				end
				S_RD: begin
					state_q <= S_CHK;
				end
				S_CHK: begin
					if (key_match || slot_empty) begin
						done_q           <= 1'b1;
						rsp_q.hit        <= key_match;
						rsp_q.table_full <= 1'b0;
						rsp_q.read_value <= (key_match && !is_set) ? rd_value : '0;
						state_q          <= S_IDLE;
					end else if (cnt_q + lpht_pkg::EFF_W'(1) == eff_q) begin
						done_q           <= 1'b1;
						rsp_q.hit        <= 1'b0;
						rsp_q.table_full <= 1'b1;
						rsp_q.read_value <= '0;
						state_q          <= S_IDLE;
					end else begin
						cnt_q   <= cnt_q + lpht_pkg::EFF_W'(1);
						idx_q   <= (idx_inc >= eff_q) ? '0 : idx_inc[lpht_pkg::IDX_W-1:0];
						state_q <= S_RD;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= req;
			eff_q <= lpht_pkg::eff_size(table_size_q);
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;
	assign rsp  = rsp_q;

	a_accept_progress: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy || done))
		else $error("accepted transaction neither started nor completed");

	a_hit_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(rsp.hit && rsp.table_full))
		else $error("hit and table_full both set");

	a_full_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.table_full) |-> (rsp.read_value == '0))
		else $error("table_full result carries a value");

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RD) |-> ({1'b0, idx_q} < eff_q))
		else $error("probe index outside slots in use");

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CHK) |-> (cnt_q < eff_q))
		else $error("probe count exceeds table size");

	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		st_ctl.we |-> (state_q == S_CHK && !done_q))
		else $error("store written outside a compare");

endmodule

FILE: verif/linear_probe_hash_table_top_tb.sv
// Linear probing hash table testbench: directed and random get/set traffic against a shadow table.
`timescale 1ns / 1ps

class lookup_scoreboard;
	logic [lpht_pkg::KEY_W-1:0]  shadow_keys [lpht_pkg::CAPACITY];
	logic [lpht_pkg::VAL_W-1:0]  shadow_vals [lpht_pkg::CAPACITY];
	logic [lpht_pkg::SIZE_W-1:0] size_reg;
	lpht_pkg::rsp_t              expected_rsp_q [$];
	int                          errors;

	function new();
		foreach (shadow_keys[i]) begin
			shadow_keys[i] = '0;
			shadow_vals[i] = '0;
		end
		size_reg = lpht_pkg::SIZE_RESET;
		errors   = 0;
	endfunction

	function void set_size(input logic [lpht_pkg::SIZE_W-1:0] v);
		size_reg = v;
	endfunction

	function int unsigned slots();
		if (size_reg == 0) begin
			return 1;
		end
		if (int'(size_reg) > lpht_pkg::CAPACITY) begin
			return lpht_pkg::CAPACITY;
		end
		return int'(size_reg);
	endfunction

	function int pending();
		return expected_rsp_q.size();
	endfunction

	function void note_request(input lpht_pkg::req_t r);
		lpht_pkg::rsp_t e;
		int unsigned    sz;
		int unsigned    idx;
		int unsigned    n;
		e = '0;
		if (r.key != '0) begin
			sz           = slots();
			idx          = r.key % sz;
			e.table_full = 1'b1;
			for (n = 0; n < sz; n++) begin
				if (shadow_keys[idx] == r.key || shadow_keys[idx] == '0) begin
					e.table_full = 1'b0;
					e.hit        = (shadow_keys[idx] == r.key);
					if (r.req_type == lpht_pkg::REQ_SET) begin
						shadow_keys[idx] = r.key;
						shadow_vals[idx] = r.write_value;
					end else if (e.hit) begin
						e.read_value = shadow_vals[idx];
					end
					break;
				end
				idx = (idx + 1 == sz) ? 0 : idx + 1;
			end
		end
		expected_rsp_q.push_back(e);
	endfunction

	function void check_response(input lpht_pkg::rsp_t a);
		lpht_pkg::rsp_t e;
		if (expected_rsp_q.size() == 0) begin
			$display("%0t: unexpected result read_value=%h hit=%b table_full=%b",
				$time, a.read_value, a.hit, a.table_full);
			errors++;
			return;
		end
		e = expected_rsp_q.pop_front();
		if (a.read_value !== e.read_value) begin
			$display("%0t: read_value expected %h actual %h", $time, e.read_value, a.read_value);
			errors++;
		end
		if (a.hit !== e.hit) begin
			$display("%0t: hit expected %b actual %b", $time, e.hit, a.hit);
			errors++;
		end
		if (a.table_full !== e.table_full) begin
			$display("%0t: table_full expected %b actual %b", $time, e.table_full, a.table_full);
			errors++;
		end
	endfunction
endclass

module linear_probe_hash_table_top_tb;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int DRAIN_CYCLES   = 600;
	localparam int POOL_N         = 12;
	localparam int PHASE_ITEMS    = 125;

	logic                        clk       = 1'b0;
	logic                        arst_n    = 1'b0;
	logic                        start     = 1'b0;
	lpht_pkg::req_t              req       = '0;
	logic                        cfg_we    = 1'b0;
	logic [lpht_pkg::SIZE_W-1:0] cfg_wdata = '0;
	logic                        busy;
	logic                        done;
	lpht_pkg::rsp_t              rsp;

	lookup_scoreboard            sb = new();
	logic [lpht_pkg::KEY_W-1:0]  key_pool [POOL_N];
	int                          quiet_cycles = 0;

	linear_probe_hash_table_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.req       (req),
		.busy      (busy),
		.done      (done),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n && done) begin
			sb.check_response(rsp);
		end
	end

	always @(posedge clk) begin
		if ((start && !busy) || done) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: watchdog expired, %0d results outstanding", $time, sb.pending());
			$display("Regression FAIL");
			$finish;
		end
	end

	task automatic wait_idle();
		while (sb.pending() != 0 || busy) begin
			@(posedge clk);
		end
	endtask

	task automatic write_size(input logic [lpht_pkg::SIZE_W-1:0] v);
		wait_idle();
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we    <= 1'b0;
		sb.set_size(v);
	endtask

	task automatic send_request(input lpht_pkg::req_t r, input int idle_pct);
		if (int'($urandom_range(99)) < idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 40)) @(posedge clk);
		end
		start <= 1'b1;
		req   <= r;
		do begin
			@(posedge clk);
		end while (busy);
		sb.note_request(r);
	endtask

	task automatic send_op(input lpht_pkg::req_type_t op,
			input logic [lpht_pkg::KEY_W-1:0] k,
			input logic [lpht_pkg::VAL_W-1:0] v);
		lpht_pkg::req_t r;
		r.req_type    = op;
		r.key         = k;
		r.write_value = v;
		send_request(r, 0);
	endtask

	task automatic finish_phase();
		start <= 1'b0;
		wait_idle();
	endtask

	task automatic run_phase(input logic [lpht_pkg::SIZE_W-1:0] size_val, input int idle_pct);
		lpht_pkg::req_t             r;
		int unsigned                es;
		int unsigned                sel;
		logic [lpht_pkg::KEY_W-1:0] k;
		write_size(size_val);
		es = sb.slots();
		foreach (key_pool[i]) begin
			k = $urandom;
			k = k - (k % es) + $urandom_range(0, (es > 4) ? 3 : es - 1);
			key_pool[i] = (k == '0) ? lpht_pkg::KEY_W'(1) : k;
		end
		for (int n = 0; n < PHASE_ITEMS; n++) begin
			sel           = $urandom_range(99);
			r.req_type    = $urandom_range(0, 1) ? lpht_pkg::REQ_SET : lpht_pkg::REQ_GET;
			r.write_value = $urandom;
			if (sel < 5) begin
				r.key = '0;
			end else if (sel < 15) begin
				r.key = $urandom;
			end else begin
				r.key = key_pool[$urandom_range(0, POOL_N - 1)];
			end
			send_request(r, idle_pct);
		end
		finish_phase();
	endtask

	initial begin
		int phase_idle [4] = '{0, 76, 0, 16};
		logic [lpht_pkg::SIZE_W-1:0] sz;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		wait_idle();

		send_op(lpht_pkg::REQ_GET, 32'h0000_0001, 32'h0000_0000);
		send_op(lpht_pkg::REQ_SET, 32'h0000_0001, 32'hFFFF_FFFF);
		send_op(lpht_pkg::REQ_GET, 32'h0000_0001, 32'h0000_0000);
		send_op(lpht_pkg::REQ_SET, 32'hFFFF_FFFF, 32'h0000_0000);
		send_op(lpht_pkg::REQ_GET, 32'hFFFF_FFFF, 32'hDEAD_BEEF);
		send_op(lpht_pkg::REQ_SET, 32'h0000_0000, 32'hA5A5_A5A5);
		send_op(lpht_pkg::REQ_GET, 32'h0000_0000, 32'h0000_0000);
		send_op(lpht_pkg::REQ_SET, 32'h0000_0101, 32'h5555_5555);
		send_op(lpht_pkg::REQ_GET, 32'h0000_0101, 32'h0000_0000);
		send_op(lpht_pkg::REQ_SET, 32'h0000_0001, 32'h1234_5678);
		send_op(lpht_pkg::REQ_GET, 32'h0000_0001, 32'h0000_0000);
		send_op(lpht_pkg::REQ_SET, 32'h0000_0100, 32'hAAAA_AAAA);
		send_op(lpht_pkg::REQ_SET, 32'h0000_0200, 32'h0F0F_0F0F);
		send_op(lpht_pkg::REQ_GET, 32'h8000_0000, 32'h0000_0000);
		finish_phase();

		write_size(lpht_pkg::SIZE_W'(2));
		send_op(lpht_pkg::REQ_GET, 32'h0000_0001, 32'h0000_0000);
		send_op(lpht_pkg::REQ_GET, 32'h0000_0101, 32'h0000_0000);
		send_op(lpht_pkg::REQ_SET, 32'h0000_0003, 32'h3333_3333);
		send_op(lpht_pkg::REQ_GET, 32'h0000_0100, 32'h0000_0000);
		finish_phase();

		write_size(lpht_pkg::SIZE_W'(0));
		send_op(lpht_pkg::REQ_GET, 32'h0000_0100, 32'h0000_0000);
		send_op(lpht_pkg::REQ_SET, 32'h0000_0005, 32'h5A5A_5A5A);
		finish_phase();

		write_size(lpht_pkg::SIZE_W'(300));
		send_op(lpht_pkg::REQ_GET, 32'h0000_0101, 32'h0000_0000);
		send_op(lpht_pkg::REQ_GET, 32'h0000_0200, 32'h0000_0000);
		finish_phase();

		for (int p = 0; p < 12; p++) begin
			case (p)
				0:       sz = lpht_pkg::SIZE_W'(256);
				1:       sz = lpht_pkg::SIZE_W'(1);
				2:       sz = lpht_pkg::SIZE_W'(16);
				3:       sz = lpht_pkg::SIZE_W'(0);
				4:       sz = lpht_pkg::SIZE_W'($urandom_range(2, 8));
				5:       sz = lpht_pkg::SIZE_W'(511);
				6:       sz = lpht_pkg::SIZE_W'($urandom_range(1, 256));
				7:       sz = lpht_pkg::SIZE_W'(3);
				8:       sz = lpht_pkg::SIZE_W'(256);
				9:       sz = lpht_pkg::SIZE_W'($urandom_range(257, 511));
				10:      sz = lpht_pkg::SIZE_W'($urandom_range(9, 64));
				default: sz = lpht_pkg::SIZE_W'(7);
			endcase
			run_phase(sz, phase_idle[p % 4]);
		end

		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.pending() != 0) begin
			$display("%0t: %0d expected results never arrived", $time, sb.pending());
		end
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
